[rtl/rbf_pkg.sv]
`timescale 1ns / 1ps
package rbf_pkg;

  localparam int FEAT_W   = 16;
  localparam int KERN_W   = 16;
  localparam int GAMMA_W  = 16;
  localparam int SUM_W    = 43;
  localparam int SQ_W     = 32;
  localparam int ARG_W    = GAMMA_W + SUM_W;
  localparam int EXP_BITS = 29;
  localparam int IDX_W    = 5;
  localparam int R_W      = 33;
  localparam int LO_W     = 32;
  localparam int HI_W     = SUM_W - LO_W;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [ARG_W-1:0] ARG_LIMIT = ARG_W'(64'd16 << 24);
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd256;

  localparam logic [0:0] REG_GAMMA = 1'b0;

  typedef logic [31:0] exp_tab_t [EXP_BITS];

  typedef struct packed {
    logic             acc_en;
    logic             mul_lo;
    logic             mul_hi;
    logic             exp_step;
    logic [IDX_W-1:0] idx;
    logic             load_out;
  } rbf_cmd_t;

  typedef struct packed {
    logic out_busy;
  } rbf_status_t;

  function automatic logic [63:0] div_small(input logic [63:0] x, input int n);
    logic [63:0] q;
    q = 64'd0;
    case (n)
      1: q = x;
      2: q = x / 64'd2;
      3: q = x / 64'd3;
      4: q = x / 64'd4;
      5: q = x / 64'd5;
      6: q = x / 64'd6;
      7: q = x / 64'd7;
      8: q = x / 64'd8;
      9: q = x / 64'd9;
      10: q = x / 64'd10;
      11: q = x / 64'd11;
      12: q = x / 64'd12;
      13: q = x / 64'd13;
      14: q = x / 64'd14;
      15: q = x / 64'd15;
      16: q = x / 64'd16;
      17: q = x / 64'd17;
      18: q = x / 64'd18;
      19: q = x / 64'd19;
      20: q = x / 64'd20;
      21: q = x / 64'd21;
      22: q = x / 64'd22;
      23: q = x / 64'd23;
      24: q = x / 64'd24;
      default: q = 64'd0;
    endcase
    return q;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] sq;
    logic        live;
    for (int b = 0; b < EXP_BITS; b++) begin
      t[b] = 32'd0;
    end
    for (int b = 0; b <= 24; b++) begin
      s = 64'd1 << 60;
      term = s;
      live = 1'b1;
      for (int n = 1; n < 64; n++) begin
        if (live) begin
          term = div_small(term >> (24 - b), n);
          if (term == 64'd0) begin
            live = 1'b0;
          end else if (n % 2 == 1) begin
            s = s - term;
          end else begin
            s = s + term;
          end
        end
      end
      t[b] = 32'((s + (64'd1 << 27)) >> 28);
    end
    for (int b = 25; b < EXP_BITS; b++) begin
      sq = {32'd0, t[b-1]} * {32'd0, t[b-1]};
      t[b] = 32'((sq + (64'd1 << 31)) >> 32);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[rtl/rbf_if.sv]
`timescale 1ns / 1ps
interface rbf_feat_if;
  logic                          valid;
  logic                          ready;
  logic signed [rbf_pkg::FEAT_W-1:0] sample_value;
  logic signed [rbf_pkg::FEAT_W-1:0] support_value;
  logic                          last_element;
  modport source (output valid, sample_value, support_value, last_element, input ready);
  modport sink (input valid, sample_value, support_value, last_element, output ready);
endinterface

interface rbf_res_if;
  logic                        valid;
  logic                        ready;
  logic [rbf_pkg::KERN_W-1:0]  kernel_value;
  logic                        sum_saturated;
  modport source (output valid, kernel_value, sum_saturated, input ready);
  modport sink (input valid, kernel_value, sum_saturated, output ready);
endinterface

[rtl/rbf_ctrl.sv]
`timescale 1ns / 1ps
module rbf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  input  rbf_pkg::rbf_status_t status,
  output rbf_pkg::rbf_cmd_t    cmd
);
  import rbf_pkg::*;

  localparam logic [2:0] S_ACC  = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_EXP  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             fire;

  assign in_ready = (state == S_ACC);
  assign fire     = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    cmd          = '0;
    cmd.idx      = idx;
    unique case (state)
      S_ACC: begin
        cmd.acc_en = fire;
        if (fire && in_last) begin
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        idx_next   = '0;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.exp_step = 1'b1;
        idx_next     = idx + 1'b1;
        if (idx == IDX_W'(EXP_BITS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end
endmodule

[rtl/rbf_dp.sv]
`timescale 1ns / 1ps
module rbf_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [rbf_pkg::GAMMA_W-1:0]        gamma,
  input  logic signed [rbf_pkg::FEAT_W-1:0]  sample_value,
  input  logic signed [rbf_pkg::FEAT_W-1:0]  support_value,
  input  logic                               last_element,
  input  rbf_pkg::rbf_cmd_t                  cmd,
  output rbf_pkg::rbf_status_t               status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rbf_pkg::KERN_W-1:0]         kernel_value,
  output logic                               sum_saturated
);
  import rbf_pkg::*;

  logic [SUM_W-1:0]           acc;
  logic                       acc_sat;
  logic [SUM_W-1:0]           snap;
  logic                       snap_sat;
  logic [GAMMA_W+LO_W-1:0]    p_lo;
  logic [ARG_W-1:0]           arg;
  logic [R_W-1:0]             r;
  logic signed [FEAT_W:0]     diff;
  logic [FEAT_W:0]            mag;
  logic [SQ_W-1:0]            sq;
  logic [SUM_W:0]             sum_wide;
  logic [SUM_W-1:0]           sum_new;
  logic                       sat_new;
  logic [GAMMA_W+HI_W-1:0]    p_hi;
  logic [R_W+32-1:0]          prod;
  logic [R_W-1:0]             r_step;
  logic [KERN_W:0]            q;
  logic [KERN_W-1:0]          kern;

  always_comb begin
    diff     = (FEAT_W+1)'(sample_value) - (FEAT_W+1)'(support_value);
    mag      = diff[FEAT_W] ? (FEAT_W+1)'(-diff) : (FEAT_W+1)'(diff);
    sq       = mag[FEAT_W-1:0] * mag[FEAT_W-1:0];
    sum_wide = {1'b0, acc} + (SUM_W+1)'(sq);
    sat_new  = sum_wide[SUM_W] || acc_sat;
    sum_new  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    p_hi     = gamma * snap[SUM_W-1:LO_W];
    prod     = r * (R_W+32)'(EXP_TAB[cmd.idx]);
    r_step   = R_W'((prod + (R_W+32)'(64'd1 << 31)) >> 32);
    q        = (KERN_W+1)'((r + R_W'(1 << 15)) >> 16);
    if (arg > ARG_LIMIT) begin
      kern = '0;
    end else if (q[KERN_W]) begin
      kern = {KERN_W{1'b1}};
    end else begin
      kern = q[KERN_W-1:0];
    end
  end

  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      acc_sat   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.acc_en) begin
        acc     <= last_element ? '0 : sum_new;
        acc_sat <= last_element ? 1'b0 : sat_new;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && last_element) begin
      snap     <= sum_new;
      snap_sat <= sat_new;
    end
    if (cmd.mul_lo) begin
      p_lo <= gamma * snap[LO_W-1:0];
    end
    if (cmd.mul_hi) begin
      arg <= {p_hi, {LO_W{1'b0}}} + ARG_W'(p_lo);
      r   <= R_W'(64'd1 << 32);
    end
    if (cmd.exp_step && arg[cmd.idx]) begin
      r <= r_step;
    end
    if (cmd.load_out) begin
      kernel_value  <= kern;
      sum_saturated <= snap_sat;
    end
  end
endmodule

[rtl/rbf_kernel.sv]
`timescale 1ns / 1ps
// Channel   Dir  Beat contents
// feat      in   sample_value, support_value, last_element
// result    out  kernel_value, sum_saturated (one beat per vector)
// apb       cfg  gamma at address 0
// A feature beat is taken every cycle while the block accumulates.
// After the last beat of a vector the block takes no beats until the result loads:
// S_MUL0 and S_MUL1 form gamma times the sum, then S_EXP steps the exponential one
// argument bit per cycle through a shared multiplier, then S_FIN loads the result.
// A stalled result holds in the output register while the next vector streams in.
// Reset is synchronous and clears the sum, the flag and gamma to 1.0.
module rbf_kernel (
  input  logic                        clk,
  input  logic                        rst,
  rbf_feat_if.sink                    feat,
  rbf_res_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbf_pkg::ADDR_W-1:0]  paddr,
  input  logic [rbf_pkg::DATA_W-1:0]  pwdata,
  output logic [rbf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import rbf_pkg::*;

  logic [GAMMA_W-1:0] gamma;
  rbf_cmd_t           cmd;
  rbf_status_t        status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GAMMA) ? DATA_W'(gamma) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_GAMMA) begin
      gamma <= pwdata[GAMMA_W-1:0];
    end
  end

  rbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feat.valid),
    .in_last  (feat.last_element),
    .in_ready (feat.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rbf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .gamma         (gamma),
    .sample_value  (feat.sample_value),
    .support_value (feat.support_value),
    .last_element  (feat.last_element),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .kernel_value  (result.kernel_value),
    .sum_saturated (result.sum_saturated)
  );
endmodule

[tb/rbf_tb_if.sv]
`timescale 1ns / 1ps
interface rbf_apb_if (input logic clk);
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [rbf_pkg::ADDR_W-1:0]  paddr;
  logic [rbf_pkg::DATA_W-1:0]  pwdata;
  logic [rbf_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  modport source (output psel, penable, pwrite, paddr, pwdata, input prdata, pready);
  modport sink (input psel, penable, pwrite, paddr, pwdata, output prdata, pready);
endinterface

[tb/rbf_kernel_test.sv]
`timescale 1ns / 1ps
module rbf_kernel_test;
  import rbf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rbf_feat_if feat ();
  rbf_res_if  result ();
  rbf_apb_if  apb (clk);

  rbf_kernel dut (
    .clk     (clk),
    .rst     (rst),
    .feat    (feat),
    .result  (result),
    .psel    (apb.psel),
    .penable (apb.penable),
    .pwrite  (apb.pwrite),
    .paddr   (apb.paddr),
    .pwdata  (apb.pwdata),
    .prdata  (apb.prdata),
    .pready  (apb.pready)
  );

  typedef struct {
    logic [KERN_W-1:0] kernel_value;
    logic              sum_saturated;
  } kernel_res_t;

  kernel_res_t       kernel_q[$];
  logic [63:0]       exp_factor[EXP_BITS];
  logic [GAMMA_W-1:0] gamma_model;
  logic [SUM_W-1:0]  dist_model;
  logic              sat_model;
  int                mismatches = 0;
  int                vectors_sent = 0;
  int                results_seen = 0;
  int                sat_seen = 0;
  int                gammas_used = 0;
  int                stall_pct = 20;

  always #4 clk = ~clk;

  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

  // Exponential factors exp(-2^(b-24)) in Q.32, built from a Taylor series.
  task automatic build_factors();
    logic [63:0] s;
    logic [63:0] term;
    for (int b = 0; b <= 24; b++) begin
      s = 64'd1 << 60;
      term = s;
      for (int n = 1; n < 64; n++) begin
        term = (term >> (24 - b)) / n;
        if (term == 64'd0) break;
        if (n % 2 == 1) s = s - term;
        else s = s + term;
      end
      exp_factor[b] = (s + (64'd1 << 27)) >> 28;
    end
    for (int b = 25; b < EXP_BITS; b++) begin
      exp_factor[b] = (exp_factor[b-1] * exp_factor[b-1] + (64'd1 << 31)) >> 32;
    end
  endtask

  function automatic logic [KERN_W-1:0] gaussian_of(logic [SUM_W-1:0] sum);
    logic [63:0] arg;
    logic [63:0] r;
    logic [63:0] q;
    arg = {48'd0, gamma_model} * {21'd0, sum};
    r = 64'd1 << 32;
    if (arg > (64'd16 << 24)) return '0;
    for (int b = 0; b < EXP_BITS; b++) begin
      if (arg[b]) r = (r * exp_factor[b] + (64'd1 << 31)) >> 32;
    end
    q = (r + (64'd1 << 15)) >> 16;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic void accumulate_feature(logic signed [FEAT_W-1:0] a,
                                             logic signed [FEAT_W-1:0] b, logic last);
    int          d;
    logic [63:0] sq;
    kernel_res_t r;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    sq = 64'(d) * 64'(d);
    if (sq > {21'd0, SUM_MAX} - {21'd0, dist_model}) begin
      dist_model = SUM_MAX;
      sat_model = 1'b1;
    end else begin
      dist_model = dist_model + sq[SUM_W-1:0];
    end
    if (last) begin
      r.kernel_value = gaussian_of(dist_model);
      r.sum_saturated = sat_model;
      kernel_q.push_back(r);
      dist_model = '0;
      sat_model = 1'b0;
    end
  endfunction

  task automatic idle_gap(int pct);
    int n;
    if ($urandom_range(99) >= pct) return;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    feat.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_feature(logic signed [FEAT_W-1:0] a, logic signed [FEAT_W-1:0] b,
                              logic last, int pct);
    idle_gap(pct);
    feat.valid <= 1'b1;
    feat.sample_value <= a;
    feat.support_value <= b;
    feat.last_element <= last;
    @(posedge clk);
    while (!feat.ready) @(posedge clk);
    accumulate_feature(a, b, last);
    if (last) vectors_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    feat.valid <= 1'b0;
    while (kernel_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_gamma(logic [GAMMA_W-1:0] g);
    drain_results();
    apb.psel <= 1'b1;
    apb.pwrite <= 1'b1;
    apb.paddr <= {REG_GAMMA, 2'b00};
    apb.pwdata <= {16'd0, g};
    @(negedge clk);
    apb.penable <= 1'b1;
    @(posedge clk);
    while (!apb.pready) @(posedge clk);
    gamma_model = g;
    gammas_used++;
    @(negedge clk);
    apb.psel <= 1'b0;
    apb.penable <= 1'b0;
    apb.pwrite <= 1'b0;
  endtask

  function automatic logic signed [FEAT_W-1:0] random_feature(int span);
    return FEAT_W'($signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic send_vector(int len, int span, int pct);
    for (int i = 0; i < len; i++) begin
      send_feature(random_feature(span), random_feature(span), i == len - 1, pct);
    end
  endtask

  task automatic test_directed();
    send_feature(16'sd0, 16'sd0, 1'b1, 0);
    send_feature(16'sd256, 16'sd0, 1'b1, 0);
    send_feature(16'sd512, -16'sd512, 1'b1, 0);
    send_feature(16'sd1024, 16'sd0, 1'b1, 0);
    send_feature(16'sd1025, 16'sd0, 1'b1, 0);
    send_feature(16'sd1, 16'sd0, 1'b0, 0);
    send_feature(-16'sd1, 16'sd0, 1'b1, 0);
    send_feature(16'sh7FFF, 16'sh8000, 1'b1, 0);
    send_feature(16'sh8000, 16'sh7FFF, 1'b1, 0);
    for (int i = 0; i < 8; i++) send_feature(16'sh7FFF, 16'sh8000, 1'b0, 0);
    send_feature(16'sh7FFF, 16'sh8000, 1'b1, 0);
    send_feature(16'shFFFF, 16'shFFFF, 1'b1, 0);
    send_feature(16'sh5555, 16'shAAAA, 1'b1, 0);
  endtask

  task automatic test_gamma_extremes();
    logic [GAMMA_W-1:0] g[5] = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'h00FF};
    foreach (g[k]) begin
      write_gamma(g[k]);
      send_feature(16'sh7FFF, 16'sh8000, 1'b1, 0);
      send_feature(16'sd1, 16'sd0, 1'b1, 0);
      send_feature(16'sd3, 16'sd0, 1'b1, 0);
      send_vector(3, 300, 10);
    end
  endtask

  task automatic test_random_streams();
    int items;
    int len;
    items = 0;
    while (items < 500) begin
      if ($urandom_range(7) == 0) begin
        write_gamma($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(512, 1)));
      end
      if ($urandom_range(9) == 0) drain_results();
      len = ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
      if ($urandom_range(9) == 0) begin
        for (int i = 0; i < len; i++) begin
          send_feature(16'($urandom), 16'($urandom), i == len - 1, 25);
        end
      end else begin
        send_vector(len, $urandom_range(3) == 0 ? 2048 : 200, 25);
      end
      items += len;
      stall_pct = $urandom_range(3) == 0 ? 0 : 30;
    end
  endtask

  initial begin
    int n;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        result.ready <= 1'b0;
        n = ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
        repeat (n - 1) @(negedge clk);
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    kernel_res_t w;
    if (!rst && result.valid && result.ready) begin
      results_seen <= results_seen + 1;
      if (result.sum_saturated) sat_seen <= sat_seen + 1;
      if (kernel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: kernel %0d sat %0b",
                                       result.kernel_value, result.sum_saturated);
      end else begin
        w = kernel_q.pop_front();
        if (result.kernel_value !== w.kernel_value ||
            result.sum_saturated !== w.sum_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected kernel %0d sat %0b, got kernel %0d sat %0b",
                     w.kernel_value, w.sum_saturated,
                     result.kernel_value, result.sum_saturated);
        end
      end
    end
  end

  initial begin
    feat.valid = 1'b0;
    feat.sample_value = '0;
    feat.support_value = '0;
    feat.last_element = 1'b0;
    apb.psel = 1'b0;
    apb.penable = 1'b0;
    apb.pwrite = 1'b0;
    apb.paddr = '0;
    apb.pwdata = '0;
    build_factors();
    gamma_model = GAMMA_RESET;
    dist_model = '0;
    sat_model = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_gamma_extremes();
    test_random_streams();
    drain_results();
    if (kernel_q.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", kernel_q.size());
    end
    $display("Covered %0d vectors, %0d results, %0d saturated, %0d gamma settings.",
             vectors_sent, results_seen, sat_seen, gammas_used);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
